// File: rtl/core/adsr_enveloped_oscillator_defines.svh
// assertion macros for the enveloped oscillator voice
`ifndef ADSR_ENVELOPED_OSCILLATOR_DEFINES_SVH
`define ADSR_ENVELOPED_OSCILLATOR_DEFINES_SVH
`ifndef SYNTH
`define AEO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define AEO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define AEO_ASSERT(lbl, prop, msg)
`define AEO_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/aeo_pkg.sv
// shared types, codes and the sine table of the enveloped oscillator
`default_nettype none
package aeo_pkg;

  // input op codes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [1:0] OP_NOTE_OFF = 2'd2;
  localparam logic [1:0] OP_RSVD     = 2'd3;

  // waveform codes
  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SQUARE = 3'd1;
  localparam logic [2:0] WAVE_TRI    = 3'd2;
  localparam logic [2:0] WAVE_RAMP_A = 3'd3;
  localparam logic [2:0] WAVE_RAMP_B = 3'd4;
  localparam logic [2:0] WAVE_NOISE  = 3'd5;

  // register indexes
  localparam logic [2:0] REG_WAVEFORM = 3'd0;
  localparam logic [2:0] REG_ATTACK   = 3'd1;
  localparam logic [2:0] REG_DECAY    = 3'd2;
  localparam logic [2:0] REG_RELEASE  = 3'd3;
  localparam logic [2:0] REG_START    = 3'd4;
  localparam logic [2:0] REG_SUSTAIN  = 3'd5;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned QUOT_W = 16;
  localparam int unsigned DIV_CNT_W = 4;

  // quarter-wave sine table
  localparam int unsigned SINE_ENTRIES = 256;
  localparam int unsigned SINE_IDX_W = $clog2(SINE_ENTRIES);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // reciprocals of the series divisors, exact for dividends below 2^33
  localparam int unsigned RCP_SHIFT = 41;
  typedef longint unsigned taylor_rcp_t [1:6];
  localparam taylor_rcp_t TAYLOR_RCP = '{
    ((64'd1 << RCP_SHIFT) + 64'd5) / 64'd6,
    ((64'd1 << RCP_SHIFT) + 64'd19) / 64'd20,
    ((64'd1 << RCP_SHIFT) + 64'd41) / 64'd42,
    ((64'd1 << RCP_SHIFT) + 64'd71) / 64'd72,
    ((64'd1 << RCP_SHIFT) + 64'd109) / 64'd110,
    ((64'd1 << RCP_SHIFT) + 64'd155) / 64'd156
  };

  typedef logic [14:0] sine_tab_t [SINE_ENTRIES+1];

  // taylor series in q30, evaluated at elaboration only
  function automatic sine_tab_t sine_build();
    sine_tab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    longint v;
    logic [95:0] wide;
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      x = (longint'(k) * HALF_PI_Q30) >> SINE_IDX_W;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int i = 1; i <= 6; i++) begin
        wide = 96'((term * x2) >> 30) * 96'(TAYLOR_RCP[i]);
        term = 64'(wide >> RCP_SHIFT);
        if ((i % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum * 32767 + (longint'(1) << 29)) >>> 30;
      if (v > 32767) v = 32767;
      tab[k] = 15'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = sine_build();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SETUP,
    ST_DIVIDE,
    ST_SCALE,
    ST_MULT,
    ST_OUTPUT
  } state_e;

  typedef enum logic [1:0] {
    AMP_DIRECT,
    AMP_QUOT,
    AMP_SUB,
    AMP_ADD
  } amp_mode_e;

  typedef struct packed {
    logic [2:0]  wave_sel;
    logic [23:0] attack_ticks;
    logic [23:0] decay_ticks;
    logic [23:0] release_ticks;
    logic [15:0] start_level;
    logic [15:0] sustain_level;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic setup;
    logic div_step;
    logic scale;
    logic mult;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/core/aeo_regs.sv
// apb configuration registers of the enveloped oscillator
`default_nettype none
module aeo_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [aeo_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output aeo_pkg::cfg_t                  cfg_o
);

  aeo_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[aeo_pkg::ADDR_W-1:2];
  assign cfg_o   = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_sel      <= aeo_pkg::WAVE_TRI;
      cfg_q.attack_ticks  <= 24'd441;
      cfg_q.decay_ticks   <= 24'd441;
      cfg_q.release_ticks <= 24'd882;
      cfg_q.start_level   <= 16'd32768;
      cfg_q.sustain_level <= 16'd26214;
    end else if (wr_en) begin
      unique case (reg_idx)
        aeo_pkg::REG_WAVEFORM: cfg_q.wave_sel      <= pwdata[2:0];
        aeo_pkg::REG_ATTACK:   cfg_q.attack_ticks  <= pwdata[23:0];
        aeo_pkg::REG_DECAY:    cfg_q.decay_ticks   <= pwdata[23:0];
        aeo_pkg::REG_RELEASE:  cfg_q.release_ticks <= pwdata[23:0];
        aeo_pkg::REG_START:    cfg_q.start_level   <= pwdata[15:0];
        aeo_pkg::REG_SUSTAIN:  cfg_q.sustain_level <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      aeo_pkg::REG_WAVEFORM: prdata = {29'd0, cfg_q.wave_sel};
      aeo_pkg::REG_ATTACK:   prdata = {8'd0, cfg_q.attack_ticks};
      aeo_pkg::REG_DECAY:    prdata = {8'd0, cfg_q.decay_ticks};
      aeo_pkg::REG_RELEASE:  prdata = {8'd0, cfg_q.release_ticks};
      aeo_pkg::REG_START:    prdata = {16'd0, cfg_q.start_level};
      aeo_pkg::REG_SUSTAIN:  prdata = {16'd0, cfg_q.sustain_level};
      default:               prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/aeo_ctrl.sv
// sequencing state machine of the enveloped oscillator
`default_nettype none
`include "adsr_enveloped_oscillator_defines.svh"
module aeo_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic [1:0]   in_op_i,
  output logic              in_ready_o,
  input  wire aeo_pkg::sts_t sts_i,
  output aeo_pkg::cmd_t     cmd_o
);

  aeo_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= aeo_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      aeo_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && (in_op_i == aeo_pkg::OP_TICK)) state_d = aeo_pkg::ST_UPDATE;
      end
      aeo_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = aeo_pkg::ST_SETUP;
      end
      aeo_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = aeo_pkg::ST_DIVIDE;
      end
      aeo_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = aeo_pkg::ST_SCALE;
      end
      aeo_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = aeo_pkg::ST_MULT;
      end
      aeo_pkg::ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = aeo_pkg::ST_OUTPUT;
      end
      aeo_pkg::ST_OUTPUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = aeo_pkg::ST_IDLE;
        end
      end
      default: state_d = aeo_pkg::ST_IDLE;
    endcase
  end

  `AEO_ASSERT(a_tick_starts_update,
    (accept && (in_op_i == aeo_pkg::OP_TICK)) |=> (state_q == aeo_pkg::ST_UPDATE),
    "tick request did not start the update step")
  `AEO_ASSERT(a_div_holds,
    (state_q == aeo_pkg::ST_DIVIDE && !sts_i.div_last) |=> (state_q == aeo_pkg::ST_DIVIDE),
    "divider left before its last step")
  `AEO_ASSERT(a_cmd_onehot,
    $onehot0({cmd_o.accept, cmd_o.update, cmd_o.setup, cmd_o.div_step, cmd_o.scale,
              cmd_o.mult, cmd_o.load_out}),
    "more than one datapath command at once")
  `AEO_ASSERT(a_load_when_free, cmd_o.load_out |-> sts_i.out_free,
    "result loaded over a pending result")

endmodule
`default_nettype wire

// File: rtl/core/aeo_dp.sv
// datapath: oscillator state, envelope divider, output scaling and result register
`default_nettype none
module aeo_dp #(
  parameter int unsigned TIME_BITS = 24
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire aeo_pkg::cmd_t cmd_i,
  output aeo_pkg::sts_t      sts_o,
  input  wire aeo_pkg::cfg_t cfg_i,
  input  wire logic [1:0]    op_i,
  input  wire logic [31:0]   phase_step_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [15:0]        out_data_o
);

  localparam int unsigned MW = (TIME_BITS > 24) ? TIME_BITS : 24;
  localparam int unsigned SW = MW + 1;
  localparam int unsigned NW = MW + aeo_pkg::QUOT_W;
  localparam int unsigned IB = aeo_pkg::SINE_IDX_W;

  // voice state
  logic [31:0]          phase_q, tone_step_q;
  logic [TIME_BITS-1:0] on_q, off_q;
  logic                 held_q;
  logic [15:0]          lfsr_q;
  logic                 lfsr_fb;

  // envelope and scaling registers
  aeo_pkg::amp_mode_e   mode_q, mode_d;
  logic [15:0]          base_q, base_d;
  logic [23:0]          den_q, den_d;
  logic [NW-1:0]        num_d;
  logic [23:0]          rem_q;
  logic [15:0]          quo_q;
  logic [aeo_pkg::DIV_CNT_W-1:0] cnt_q;
  logic signed [15:0]   wave_q, wave_d;
  logic [15:0]          amp_q, amp_d;
  logic signed [32:0]   prod_q;
  logic                 out_valid_q;
  logic [15:0]          out_data_q, sat_d;

  assign lfsr_fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];

  // voice state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      tone_step_q <= '0;
      on_q        <= '0;
      off_q       <= '1;
      held_q      <= 1'b0;
      lfsr_q      <= 16'hACE1;
    end else if (cmd_i.accept) begin
      if (op_i == aeo_pkg::OP_NOTE_ON) begin
        tone_step_q <= phase_step_i;
        on_q        <= '0;
        held_q      <= 1'b1;
      end else if (op_i == aeo_pkg::OP_NOTE_OFF) begin
        off_q  <= '0;
        held_q <= 1'b0;
      end
    end else if (cmd_i.update) begin
      phase_q <= phase_q + tone_step_q;
      if (on_q != '1)  on_q  <= on_q + 1'b1;
      if (off_q != '1) off_q <= off_q + 1'b1;
      lfsr_q <= {lfsr_fb, lfsr_q[15:1]};
    end
  end

  // envelope segment select and numerator product
  logic [SW-1:0] life_x, off_x, a_x, d_x, r_x, t_x, ro_x;
  logic [MW-1:0] mul_a;
  logic [15:0]   mul_b;

  always_comb begin
    life_x = SW'(on_q);
    off_x  = SW'(off_q);
    a_x    = SW'(cfg_i.attack_ticks);
    d_x    = SW'(cfg_i.decay_ticks);
    r_x    = SW'(cfg_i.release_ticks);
    t_x    = life_x - a_x;
    ro_x   = r_x - off_x;
    mode_d = aeo_pkg::AMP_DIRECT;
    base_d = '0;
    den_d  = cfg_i.attack_ticks;
    mul_a  = MW'(life_x);
    mul_b  = cfg_i.start_level;
    if (held_q) begin
      if (life_x <= a_x) begin
        base_d = cfg_i.start_level;
        if (cfg_i.attack_ticks != '0) mode_d = aeo_pkg::AMP_QUOT;
      end else if (life_x <= a_x + d_x) begin
        base_d = cfg_i.start_level;
        den_d  = cfg_i.decay_ticks;
        mul_a  = MW'(t_x);
        if (cfg_i.start_level >= cfg_i.sustain_level) begin
          mode_d = aeo_pkg::AMP_SUB;
          mul_b  = cfg_i.start_level - cfg_i.sustain_level;
        end else begin
          mode_d = aeo_pkg::AMP_ADD;
          mul_b  = cfg_i.sustain_level - cfg_i.start_level;
        end
      end else begin
        base_d = cfg_i.sustain_level;
      end
    end else begin
      den_d = cfg_i.release_ticks;
      mul_a = MW'(ro_x);
      mul_b = cfg_i.sustain_level;
      if (cfg_i.release_ticks != '0 && off_x < r_x) mode_d = aeo_pkg::AMP_QUOT;
    end
    num_d = NW'(mul_a) * NW'(mul_b);
  end

  // waveform from the updated phase
  logic [IB-1:0]   sidx;
  logic [IB:0]     midx;
  logic [14:0]     smag;
  logic signed [15:0] sine_v;
  logic [16:0]     tri_v, tri_m;

  always_comb begin
    sidx   = phase_q[29 -: IB];
    midx   = phase_q[30] ? ((IB+1)'(aeo_pkg::SINE_ENTRIES) - {1'b0, sidx}) : {1'b0, sidx};
    smag   = aeo_pkg::SINE_TAB[midx];
    sine_v = phase_q[31] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
    tri_v  = phase_q[31:15];
    tri_m  = 17'd65536 - tri_v;
    case (cfg_i.wave_sel)
      aeo_pkg::WAVE_SINE:   wave_d = sine_v;
      aeo_pkg::WAVE_SQUARE: wave_d = (sine_v > 16'sd0) ? 16'sd32767 : -16'sd32768;
      aeo_pkg::WAVE_TRI: begin
        case (tri_v[16:15])
          2'b00:   wave_d = $signed({1'b0, tri_v[14:0]});
          2'b11:   wave_d = $signed(tri_v[15:0]);
          // falling edge, only its top point clips
          default: wave_d = (tri_v == 17'd32768) ? 16'sd32767 : $signed(tri_m[15:0]);
        endcase
      end
      aeo_pkg::WAVE_RAMP_A, aeo_pkg::WAVE_RAMP_B:
        wave_d = $signed({~phase_q[31], phase_q[30:16]});
      aeo_pkg::WAVE_NOISE:  wave_d = $signed({~lfsr_q[15], lfsr_q[14:0]});
      default:              wave_d = '0;
    endcase
  end

  // restoring divider, one quotient bit a cycle
  logic [24:0] dsh;
  logic        dge;

  assign dsh = {rem_q, quo_q[15]};
  assign dge = dsh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.setup) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      mode_q <= mode_d;
      base_q <= base_d;
      den_q  <= den_d;
      rem_q  <= num_d[aeo_pkg::QUOT_W +: 24];
      quo_q  <= num_d[aeo_pkg::QUOT_W-1:0];
      wave_q <= wave_d;
    end else if (cmd_i.div_step) begin
      rem_q <= dge ? 24'(dsh - {1'b0, den_q}) : dsh[23:0];
      quo_q <= {quo_q[14:0], dge};
    end
    if (cmd_i.scale) amp_q <= amp_d;
    if (cmd_i.mult)  prod_q <= wave_q * $signed({1'b0, amp_q});
  end

  assign sts_o.div_last = (cnt_q == '1);

  // amplitude from the segment mode, small values squelched
  logic [15:0] amp_raw;
  always_comb begin
    case (mode_q)
      aeo_pkg::AMP_QUOT: amp_raw = quo_q;
      aeo_pkg::AMP_SUB:  amp_raw = base_q - quo_q;
      aeo_pkg::AMP_ADD:  amp_raw = base_q + quo_q;
      default:           amp_raw = base_q;
    endcase
    amp_d = (amp_raw < 16'd4) ? 16'd0 : amp_raw;
  end

  // floor shift and saturation
  logic signed [17:0] q_v;
  always_comb begin
    q_v = 18'(prod_q >>> 15);
    if (q_v > 18'sd32767)       sat_d = 16'h7FFF;
    else if (q_v < -18'sd32768) sat_d = 16'h8000;
    else                        sat_d = q_v[15:0];
  end

  // result register
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_data_q <= sat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// File: rtl/core/adsr_enveloped_oscillator.sv
// top level of the adsr enveloped oscillator voice
// One synthesizer voice. Requests arrive on the s_axis channel: tuser carries the op
// (tick, note on, note off) and tdata the phase step that a note on loads. Every tick
// request yields one signed Q1.15 sample on m_axis; note on and note off yield none.
// A note request only updates the voice state and leaves the controller idle. A tick
// request passes from acceptance to the result register through the state update,
// envelope setup with one 16 x max(TIME_BITS, 24) product, a 16-step restoring divider,
// amplitude scaling, the wave times amplitude product and the result load. One tick
// is in work at a time; a new request is taken only after its result load.
// The result register holds a sample while the receiver stalls; the next request is
// still taken and worked on, and waits at the load step only if the register is full.
// Reset silences the voice: phase, tone step and counters clear, the release counter
// saturates, the noise register loads its seed and the registers take their defaults.
// The user writes configuration over the apb port while the voice is idle; unchecked.
`default_nettype none
module adsr_enveloped_oscillator #(
  parameter int unsigned TIME_BITS = 24
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [31:0]               s_axis_tdata,  // phase_step[31:0]
  input  wire logic [1:0]                s_axis_tuser,  // op[1:0]
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // sample[15:0]
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [aeo_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  aeo_pkg::cfg_t cfg;
  aeo_pkg::cmd_t cmd;
  aeo_pkg::sts_t sts;

  // configuration registers
  aeo_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // controller
  aeo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  aeo_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_i        (cfg),
    .op_i         (s_axis_tuser),
    .phase_step_i (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

endmodule
`default_nettype wire
